// ----- rtl/orp_pkg.sv -----
// shared types and constants for the reuse predictor
`default_nettype none
package orp_pkg;
    localparam int unsigned SETS        = 2048;
    localparam int unsigned HIST_LEN    = 128;
    localparam int unsigned PRED_ENT    = 8192;
    localparam int unsigned OFFSET_BITS = 6;
    localparam int unsigned SET_W       = $clog2(SETS);
    localparam int unsigned HIST_W      = $clog2(HIST_LEN);
    localparam int unsigned PRED_W      = $clog2(PRED_ENT);
    localparam int unsigned TAG_W       = 16;
    localparam int unsigned OCC_W       = 5;
    localparam int unsigned CTR_W       = 3;
    // one history slot: valid, tag, occupancy
    localparam int unsigned SLOT_W      = 1 + TAG_W + OCC_W;
    localparam int unsigned ROW_W       = SLOT_W * HIST_LEN;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 5;

    localparam logic [1:0] FUNC_TRAIN   = 2'd0;
    localparam logic [1:0] FUNC_PREDICT = 2'd1;
    localparam logic [1:0] FUNC_EVICT   = 2'd2;

    localparam logic [1:0] OPT_MISS  = 2'd0;
    localparam logic [1:0] OPT_HIT   = 2'd1;
    localparam logic [1:0] OPT_NONE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'd1;

    localparam logic [CTR_W-1:0] CTR_RESET = 3'd4;
    localparam logic [CTR_W-1:0] CTR_MAX   = 3'd7;
    localparam logic [2:0]       RRIP_FAR  = 3'd7;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] addr;
        logic [12:0] victim_index;
        logic        victim_friendly;
    } req_t;

    typedef struct packed {
        logic [1:0]  opt_result;
        logic        cache_friendly;
        logic [12:0] predictor_index;
        logic [2:0]  insert_rrip;
    } rsp_t;
endpackage
`default_nettype wire

// ----- rtl/optgen_reuse_predictor.sv -----
// top level: optgen history trainer and reuse counter predictor
// One request at a time, in states READ, WAIT and WRITE plus output hand-off:
// a read state for the set's history row, head and counter, a wait state for the
// read data, then a write state that updates and writes back the row, head and
// counter in a single read-modify-write. After reset a clearing pass
// sweeps the history rows, heads and counters, during which no request is
// taken; configuration writes are accepted at all times.
`default_nettype none
module optgen_reuse_predictor import orp_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire req_t                  in_data,
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      rsp_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_WAIT, S_WRITE, S_OUT} state_t;

    state_t             state_reg;
    logic [PRED_W-1:0]  clr_reg;
    logic [CTR_W-1:0]   thr_reg;
    logic [OCC_W-1:0]   cap_reg;
    req_t               req_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    logic [ROW_W-1:0]   row_q;
    logic [HIST_W-1:0]  head_q;
    logic [CTR_W-1:0]   ctr_q;
    logic [ROW_W-1:0]   row_new;
    logic [1:0]         opt_new;
    logic [ROW_W-1:0]   row_wdata;
    logic [HIST_W-1:0]  head_wdata;
    logic [CTR_W-1:0]   ctr_wdata;
    logic               we;
    logic [SET_W-1:0]   set_addr;
    logic [PRED_W-1:0]  ctr_addr;
    logic [31:0]        block;
    logic [SET_W-1:0]   req_set;
    logic [TAG_W-1:0]   req_tag;
    logic [PRED_W-1:0]  req_pidx;
    logic [PRED_W-1:0]  vidx;
    logic               friendly;

    // address split
    assign block    = req_reg.addr >> OFFSET_BITS;
    assign req_set  = block[SET_W-1:0];
    assign req_tag  = block[SET_W +: TAG_W];
    assign req_pidx = req_reg.addr[PRED_W-1:0];
    assign vidx     = req_reg.victim_index[PRED_W-1:0];
    assign friendly = ctr_q > thr_reg;

    // memory addressing: clear sweep or current request
    always_comb
    begin
        set_addr = req_set;
        ctr_addr = (req_reg.func == FUNC_EVICT) ? vidx : req_pidx;
        we = 1'b0;
        row_wdata = row_new;
        head_wdata = head_q + HIST_W'(1);
        ctr_wdata = ctr_q;
        if (state_reg == S_CLEAR)
        begin
            set_addr = clr_reg[SET_W-1:0];
            ctr_addr = clr_reg;
            we = 1'b1;
            row_wdata = '0;
            head_wdata = '0;
            ctr_wdata = CTR_RESET;
        end
        else if (state_reg == S_WRITE)
        begin
            we = 1'b1;
            if (req_reg.func == FUNC_TRAIN)
            begin
                if (opt_new == OPT_HIT && ctr_q != CTR_MAX)
                begin
                    ctr_wdata = ctr_q + CTR_W'(1);
                end
                else if (opt_new == OPT_MISS && ctr_q != '0)
                begin
                    ctr_wdata = ctr_q - CTR_W'(1);
                end
            end
            else
            begin
                row_wdata = row_q;
                head_wdata = head_q;
                if (req_reg.func == FUNC_EVICT && req_reg.victim_friendly && ctr_q != '0)
                begin
                    ctr_wdata = ctr_q - CTR_W'(1);
                end
            end
        end
    end

    // history rows, heads, counters
    orp_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_rows (
        .clk(clk), .we(we), .addr(set_addr), .wdata(row_wdata), .rdata(row_q));
    orp_ram #(.WIDTH(HIST_W), .DEPTH(SETS)) u_heads (
        .clk(clk), .we(we), .addr(set_addr), .wdata(head_wdata), .rdata(head_q));
    orp_ram #(.WIDTH(CTR_W), .DEPTH(PRED_ENT)) u_ctrs (
        .clk(clk), .we(we), .addr(ctr_addr), .wdata(ctr_wdata), .rdata(ctr_q));

    orp_row_update u_upd (
        .row_in(row_q), .head(head_q), .tag(req_tag), .capacity(cap_reg),
        .row_out(row_new), .opt_result(opt_new));

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign out_data  = rsp_reg;

    // response for the current request
    always_comb
    begin
        rsp_next = '0;
        rsp_next.opt_result = OPT_NONE;
        unique case (req_reg.func)
            FUNC_TRAIN:
            begin
                rsp_next.opt_result      = opt_new;
                rsp_next.predictor_index = req_pidx;
            end
            FUNC_PREDICT:
            begin
                rsp_next.cache_friendly  = friendly;
                rsp_next.predictor_index = req_pidx;
                rsp_next.insert_rrip     = friendly ? 3'd0 : RRIP_FAR;
            end
            FUNC_EVICT:
            begin
                rsp_next.cache_friendly  = req_reg.victim_friendly;
                rsp_next.predictor_index = vidx;
            end
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 3'd3;
            cap_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: thr_reg <= cfg_data[CTR_W-1:0];
                CFG_CAPACITY:  cap_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + PRED_W'(1);
                    if (clr_reg == PRED_W'(PRED_ENT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg   <= in_data;
                        state_reg <= S_READ;
                    end
                end
                S_READ:  state_reg <= S_WAIT;
                S_WAIT:  state_reg <= S_WRITE;
                S_WRITE:
                begin
                    rsp_reg   <= rsp_next;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/orp_ram.sv -----
// generic single port synchronous ram with registered read
`default_nettype none
module orp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- rtl/orp_row_update.sv -----
// optgen row update: newest match search, capacity check, occupancy bump
`default_nettype none
module orp_row_update import orp_pkg::*; (
    input  wire logic [ROW_W-1:0]  row_in,
    input  wire logic [HIST_W-1:0] head,
    input  wire logic [TAG_W-1:0]  tag,
    input  wire logic [OCC_W-1:0]  capacity,
    output      logic [ROW_W-1:0]  row_out,
    output      logic [1:0]        opt_result
);
    logic [HIST_LEN-1:0] match_vec;
    logic [HIST_LEN-1:0] match_rot;
    logic [HIST_LEN-1:0] blk_rot;
    logic [HIST_LEN-1:0] span_rot;
    logic [HIST_LEN-1:0] span_vec;
    logic [HIST_LEN-1:0] blk_vec;
    logic [HIST_LEN-1:0] seen;
    logic                found;
    logic                blocked;

    // per-slot match and blocking flags
    always_comb
    begin
        for (int i = 0; i < HIST_LEN; i++)
        begin
            match_vec[i] = row_in[i*SLOT_W + SLOT_W - 1]
                && (row_in[i*SLOT_W + OCC_W +: TAG_W] == tag)
                && (i[HIST_W-1:0] != head);
            blk_vec[i] = row_in[i*SLOT_W +: OCC_W] >= capacity;
        end
    end

    // rotate so that distance k from head sits at bit k
    always_comb
    begin
        for (int k = 0; k < HIST_LEN; k++)
        begin
            match_rot[k] = match_vec[HIST_W'(head - HIST_W'(k))];
            blk_rot[k]   = blk_vec[HIST_W'(head - HIST_W'(k))];
        end
    end

    // span from nearest match back to head, inclusive of match, excl head
    always_comb
    begin
        seen = '0;
        seen[0] = 1'b0;
        for (int k = 1; k < HIST_LEN; k++)
        begin
            seen[k] = seen[k-1] | match_rot[k-1];
        end
        found = |match_rot;
        for (int k = 0; k < HIST_LEN; k++)
        begin
            span_rot[k] = (k != 0) && !seen[k];
        end
        span_rot = span_rot & ~{HIST_LEN{~found}};
        blocked = |(span_rot & blk_rot);
        for (int i = 0; i < HIST_LEN; i++)
        begin
            span_vec[i] = span_rot[HIST_W'(head - HIST_W'(i))];
        end
    end

    // new slot at head, bump occupancies on a hit
    always_comb
    begin
        row_out = row_in;
        for (int i = 0; i < HIST_LEN; i++)
        begin
            if (i[HIST_W-1:0] == head)
            begin
                row_out[i*SLOT_W +: SLOT_W] = {1'b1, tag, OCC_W'(1)};
            end
            else if (found && !blocked && span_vec[i])
            begin
                row_out[i*SLOT_W +: OCC_W] = row_in[i*SLOT_W +: OCC_W] + OCC_W'(1);
            end
        end
        if (!found)
        begin
            opt_result = OPT_NONE;
        end
        else if (blocked)
        begin
            opt_result = OPT_MISS;
        end
        else
        begin
            opt_result = OPT_HIT;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/orp_checker.sv -----
// port-level checker for the reuse predictor, bound to the top level
`default_nettype none
module orp_checker import orp_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire rsp_t out_data
);
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // no request taken while a result waits
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request accepted while result pending");

    // accepted request gives no early result
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid ##1 !out_valid ##1 !out_valid)
        else $error("result too early");

    // rrip only far or near, and far only with the flag clear
    a_rrip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.insert_rrip != 3'd0 |->
        out_data.insert_rrip == RRIP_FAR && !out_data.cache_friendly)
        else $error("bad insertion rrip");
endmodule

bind optgen_reuse_predictor orp_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
`default_nettype wire

// ----- dv/tb.sv -----
// self-checking testbench for the optgen reuse trainer and predictor
`timescale 1ns / 100ps
module tb;
    import orp_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    // reuse predictor scoreboard: own copy of history, counters and registers
    class reuse_scoreboard;
        logic [TAG_W-1:0]  hist_tag [int];
        logic [OCC_W-1:0]  hist_occ [int];
        logic [HIST_W-1:0] set_head [SETS];
        logic [CTR_W-1:0]  reuse_ctr [PRED_ENT];
        logic [2:0]        threshold;
        logic [4:0]        capacity;
        rsp_t              pending_rsp [$];
        int                errors;

        function new();
            foreach (set_head[i]) set_head[i] = '0;
            foreach (reuse_ctr[i]) reuse_ctr[i] = CTR_RESET;
            threshold = 3'd3;
            capacity  = 5'd16;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_THRESHOLD)
                threshold = val[2:0];
            else
                capacity = val;
        endfunction

        // history walk: returns miss, hit or first access
        function logic [1:0] train_history(logic [31:0] addr);
            logic [25:0]       blk;
            int                set_base;
            logic [TAG_W-1:0]  tag;
            logic [HIST_W-1:0] head;
            logic [HIST_W-1:0] slot;
            int                gap;
            bit                blocked;
            blk      = addr[31:OFFSET_BITS];
            set_base = int'(blk[SET_W-1:0]) * HIST_LEN;
            tag      = TAG_W'(blk[25:SET_W]);
            head     = set_head[blk[SET_W-1:0]];
            hist_tag[set_base + head] = tag;
            hist_occ[set_base + head] = 5'd1;
            set_head[blk[SET_W-1:0]] = head + 1'b1;
            gap = 0;
            for (int k = 1; k < HIST_LEN; k++)
            begin
                slot = head - HIST_W'(k);
                if (gap == 0 && hist_tag.exists(set_base + slot) &&
                    hist_tag[set_base + slot] == tag)
                    gap = k;
            end
            if (gap == 0)
                return OPT_NONE;
            blocked = 0;
            for (int k = 0; k < gap; k++)
            begin
                slot = head - HIST_W'(gap) + HIST_W'(k);
                if ((hist_occ.exists(set_base + slot) ? hist_occ[set_base + slot] : 5'd0)
                    >= capacity)
                    blocked = 1;
            end
            if (blocked)
                return OPT_MISS;
            for (int k = 0; k < gap; k++)
            begin
                slot = head - HIST_W'(gap) + HIST_W'(k);
                hist_occ[set_base + slot] =
                    (hist_occ.exists(set_base + slot) ? hist_occ[set_base + slot] : 5'd0) + 1'b1;
            end
            return OPT_HIT;
        endfunction

        // note an accepted request and queue its expected response
        function void note_request(req_t r);
            rsp_t             e;
            logic [PRED_W-1:0] pidx;
            e    = '0;
            pidx = r.addr[PRED_W-1:0];
            e.opt_result = OPT_NONE;
            if (r.func == FUNC_TRAIN)
            begin
                e.opt_result = train_history(r.addr);
                if (e.opt_result == OPT_HIT && reuse_ctr[pidx] != CTR_MAX)
                    reuse_ctr[pidx]++;
                else if (e.opt_result == OPT_MISS && reuse_ctr[pidx] != 0)
                    reuse_ctr[pidx]--;
                e.predictor_index = pidx;
            end
            else if (r.func == FUNC_PREDICT)
            begin
                e.cache_friendly  = reuse_ctr[pidx] > threshold;
                e.insert_rrip     = e.cache_friendly ? 3'd0 : RRIP_FAR;
                e.predictor_index = pidx;
            end
            else if (r.func == FUNC_EVICT)
            begin
                if (r.victim_friendly && reuse_ctr[r.victim_index] != 0)
                    reuse_ctr[r.victim_index]--;
                e.cache_friendly  = r.victim_friendly;
                e.predictor_index = r.victim_index;
            end
            pending_rsp.push_back(e);
        endfunction

        // compare a response with the oldest expectation
        function void check_response(rsp_t a);
            rsp_t e;
            if (pending_rsp.size() == 0)
            begin
                $error("response with nothing expected: %h", a);
                errors++;
                return;
            end
            e = pending_rsp.pop_front();
            if (a.opt_result != e.opt_result)
            begin
                $error("opt_result expected %0d got %0d", e.opt_result, a.opt_result);
                errors++;
            end
            if (a.cache_friendly != e.cache_friendly)
            begin
                $error("cache_friendly expected %0d got %0d", e.cache_friendly, a.cache_friendly);
                errors++;
            end
            if (a.predictor_index != e.predictor_index)
            begin
                $error("predictor_index expected %0d got %0d",
                       e.predictor_index, a.predictor_index);
                errors++;
            end
            if (a.insert_rrip != e.insert_rrip)
            begin
                $error("insert_rrip expected %0d got %0d", e.insert_rrip, a.insert_rrip);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    req_t                  in_data;
    logic                  out_valid;
    logic                  out_stall;
    rsp_t                  out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    reuse_scoreboard sb;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              quiet_cycles;
    logic [14:0]     tag_pool [6];
    logic [10:0]     set_pool [4];

    optgen_reuse_predictor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // response side: random stall, check, watchdog
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_response(out_data);
        if ((out_valid && !out_stall) || (in_valid && !in_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("optgen_reuse_predictor test failed");
            $finish;
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // drive one request, with random idle cycles ahead of it
    task automatic send_request(req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_stall);
        sb.note_request(r);
    endtask

    task automatic send_fields(logic [1:0] f, logic [31:0] a, logic [12:0] vi, logic vf);
        req_t r;
        r.func            = f;
        r.addr            = a;
        r.victim_index    = vi;
        r.victim_friendly = vf;
        send_request(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // mostly reuse-heavy traffic over a few sets, some noise
    task automatic random_phase(int count);
        req_t        r;
        logic [31:0] a;
        int          pick;
        for (int i = 0; i < count; i++)
        begin
            a = {tag_pool[$urandom_range(5)], set_pool[$urandom_range(3)],
                 6'($urandom)};
            pick = $urandom_range(99);
            r.addr            = a;
            r.victim_index    = 13'($urandom);
            r.victim_friendly = 1'($urandom);
            if (pick < 60)
                r.func = FUNC_TRAIN;
            else if (pick < 78)
                r.func = FUNC_PREDICT;
            else if (pick < 92)
            begin
                r.func = FUNC_EVICT;
                if ($urandom_range(1))
                    r.victim_index = a[12:0];
            end
            else
            begin
                r.func = 2'($urandom);
                r.addr = $urandom;
            end
            send_request(r);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n          = 1'b0;
        in_valid       <= 1'b0;
        in_data        <= '0;
        out_stall      <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every function, saturation, unused func
        write_reg(CFG_THRESHOLD, 5'd3);
        write_reg(CFG_CAPACITY, 5'd16);
        send_fields(FUNC_PREDICT, 32'h0, 13'h0, 1'b0);
        send_fields(FUNC_TRAIN, 32'h0, 13'h0, 1'b0);
        repeat (5) send_fields(FUNC_TRAIN, 32'h0, 13'h0, 1'b0);
        send_fields(FUNC_PREDICT, 32'h0, 13'h1FFF, 1'b1);
        send_fields(FUNC_TRAIN, 32'hFFFF_FFFF, 13'h0, 1'b0);
        send_fields(FUNC_TRAIN, 32'hFFFF_FFFF, 13'h0, 1'b0);
        send_fields(FUNC_PREDICT, 32'hFFFF_FFFF, 13'h0, 1'b0);
        send_fields(FUNC_EVICT, 32'h0, 13'h1FFF, 1'b1);
        send_fields(FUNC_EVICT, 32'hFFFF_FFFF, 13'h0, 1'b0);
        repeat (5) send_fields(FUNC_EVICT, 32'h0, 13'h5, 1'b1);
        send_fields(FUNC_PREDICT, 32'h5, 13'h0, 1'b0);
        send_fields(2'd3, 32'hFFFF_FFFF, 13'h1FFF, 1'b1);
        drain();

        // zero capacity: every repeat is a miss
        write_reg(CFG_CAPACITY, 5'd0);
        write_reg(CFG_THRESHOLD, 5'd7);
        send_fields(FUNC_TRAIN, 32'h40, 13'h0, 1'b0);
        send_fields(FUNC_TRAIN, 32'h40, 13'h0, 1'b0);
        send_fields(FUNC_PREDICT, 32'h40, 13'h0, 1'b0);
        drain();

        foreach (tag_pool[i]) tag_pool[i] = 15'($urandom);
        foreach (set_pool[i]) set_pool[i] = 11'($urandom);
        tag_pool[0] = 15'h7FFF;

        // sender idles lightly, receiver stalls heavily
        write_reg(CFG_THRESHOLD, 5'd0);
        write_reg(CFG_CAPACITY, 5'd1);
        send_idle_pct = 12; recv_stall_pct = 58;
        random_phase(170);
        drain();

        // roles swapped
        write_reg(CFG_THRESHOLD, 5'd7);
        write_reg(CFG_CAPACITY, 5'd16);
        send_idle_pct = 58; recv_stall_pct = 12;
        random_phase(170);
        drain();

        // full rate
        write_reg(CFG_THRESHOLD, 5'($urandom_range(7)));
        write_reg(CFG_CAPACITY, 5'($urandom_range(2, 8)));
        send_idle_pct = 0; recv_stall_pct = 0;
        random_phase(170);
        drain();
        repeat (20) @(posedge clk);

        if (sb.errors == 0)
            $display("optgen_reuse_predictor test passed");
        else
            $display("optgen_reuse_predictor test failed");
        $finish;
    end
endmodule

// ----- optgen_reuse_predictor.f -----
rtl/orp_pkg.sv
rtl/orp_ram.sv
rtl/orp_row_update.sv
rtl/optgen_reuse_predictor.sv
rtl/orp_checker.sv
dv/tb.sv
